// ===== hw/rtl/sitd_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
// Used by the divide-by-ten stages, the character serializer and the top level.
// No dependencies.
package sitd_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DIGIT_W    = 4;
  // 2^32 < 10^10, so ten digits always cover the magnitude
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIV_STAGES = NUM_DIGITS - 1;
  localparam int unsigned DIGS_W     = DIV_STAGES * DIGIT_W;
  localparam int unsigned CHAR_W     = 6;

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // One number in flight: sign, remaining quotient, digits found so far.
  // Newest digit sits in the low nibble of digs.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [DIGS_W-1:0]  digs;
  } item_t;

endpackage

// ===== hw/rtl/sitd_div10.sv =====
// One pipeline stage: divides the running magnitude by ten and shifts the
// remainder into the digit vector. Depends on sitd_pkg.
module sitd_div10 (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sitd_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output sitd_pkg::item_t out_item
);
  import sitd_pkg::*;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quo;
  logic [VALUE_W-1:0]   quo10;
  logic [VALUE_W-1:0]   rem;
  item_t                item_next;

  assign prod  = in_item.mag * RECIP10;
  assign quo   = VALUE_W'(prod >> RECIP10_SHIFT);
  assign quo10 = (quo << 3) + (quo << 1);
  assign rem   = in_item.mag - quo10;

  always_comb begin
    item_next.neg  = in_item.neg;
    item_next.mag  = quo;
    item_next.digs = {in_item.digs[DIGS_W-DIGIT_W-1:0], rem[DIGIT_W-1:0]};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== hw/rtl/sitd_serializer.sv =====
// Takes a fully split number and sends its text one character per request,
// sign first, leading zeros skipped, last character flagged. Depends on sitd_pkg.
module sitd_serializer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sitd_pkg::item_t              in_item,
  output logic                         char_valid,
  input  logic                         char_ready,
  output logic [sitd_pkg::CHAR_W-1:0]  char_data,
  output logic                         char_last
);
  import sitd_pkg::*;

  localparam int unsigned  POS_W    = $clog2(NUM_DIGITS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

  // digit j (0 = most significant) at [DIGIT_W*j +: DIGIT_W]
  logic [NUM_DIGITS*DIGIT_W-1:0] full_digs;
  logic [NUM_DIGITS*DIGIT_W-1:0] digs;
  logic [POS_W-1:0]              first_pos;
  logic [POS_W-1:0]              pos;
  logic [DIGIT_W-1:0]            cur_digit;
  logic                          busy;
  logic                          sign_pend;
  logic                          out_free;

  assign full_digs = {in_item.digs, in_item.mag[DIGIT_W-1:0]};

  // first nonzero digit; zero keeps only the ones digit
  always_comb begin
    first_pos = LAST_POS;
    for (int j = NUM_DIGITS - 1; j >= 0; j--) begin
      if (full_digs[DIGIT_W*j +: DIGIT_W] != '0) begin
        first_pos = POS_W'(j);
      end
    end
  end

  assign cur_digit = digs[DIGIT_W*pos +: DIGIT_W];
  assign out_free  = !char_valid || char_ready;
  assign in_ready  = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      sign_pend  <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (!busy && in_valid) begin
        busy      <= 1'b1;
        digs      <= full_digs;
        pos       <= first_pos;
        sign_pend <= in_item.neg;
      end
      if (out_free) begin
        char_valid <= busy;
        if (busy) begin
          if (sign_pend) begin
            char_data <= CHAR_MINUS;
            char_last <= 1'b0;
            sign_pend <= 1'b0;
          end else begin
            char_data <= CHAR_ZERO + CHAR_W'(cur_digit);
            char_last <= (pos == LAST_POS);
            pos       <= pos + 1'b1;
            if (pos == LAST_POS) begin
              busy <= 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text. Each input request carries one
// two's complement value; the output stream carries its text one character
// per request, most significant first, with '-' ahead of negative values,
// leading zeros dropped, zero as a single '0', and tlast on the final
// character (the most negative value gives "-2147483648"). A value goes
// through a sign stage and nine divide-by-ten stages (one 32x32 reciprocal
// multiply each), then a serializer load, before its first character is
// presented. The pipeline takes a value every cycle until it fills; the
// sustained rate is set by the output serializer, which loads a value and
// then sends its characters one per output transfer, and takes no new value
// until it has put out the last character of the current one.
// Depends on sitd_pkg, sitd_div10 and sitd_serializer.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] text_char, [7:6] zero
  output logic        m_axis_tlast    // last_char
);
  import sitd_pkg::*;

  logic  vld [DIV_STAGES+1];
  logic  rdy [DIV_STAGES+1];
  item_t itm [DIV_STAGES+1];
  item_t sign_next;
  logic [CHAR_W-1:0] char_data;

  // sign stage: magnitude as unsigned, so the most negative value stays exact
  always_comb begin
    sign_next.neg  = s_axis_tdata[VALUE_W-1];
    sign_next.mag  = s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;
    sign_next.digs = '0;
  end

  assign s_axis_tready = !vld[0] || rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (s_axis_tready) begin
      vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      itm[0] <= sign_next;
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    sitd_div10 u_div10 (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_item   (itm[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_item  (itm[i+1])
    );
  end

  sitd_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (vld[DIV_STAGES]),
    .in_ready   (rdy[DIV_STAGES]),
    .in_item    (itm[DIV_STAGES]),
    .char_valid (m_axis_tvalid),
    .char_ready (m_axis_tready),
    .char_data  (char_data),
    .char_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, char_data};

endmodule

// ===== test/signed_int_to_decimal_ascii_checker.sv =====
// Checker for signed_int_to_decimal_ascii: watches both stream ports, predicts the
// decimal text of every accepted value and compares each output character in order.
// Depends on sitd_pkg for the character codes.
module signed_int_to_decimal_ascii_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [5:0] text_char, [7:6] zero
  input  logic        m_axis_tlast,   // last_char
  output int          errors,
  output int          pending,
  output int          n_values,
  output int          n_chars
);
  timeunit 1ns;
  timeprecision 1ps;
  import sitd_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  text_char_t text_q[$];

  initial begin
    errors   = 0;
    pending  = 0;
    n_values = 0;
    n_chars  = 0;
  end

  // Decimal text of one value, most significant character first.
  task automatic format_decimal(input logic [31:0] value);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  digs[NUM_DIGITS];
    int          nd;
    neg = value[31];
    // unsigned negate, so the most negative value keeps its magnitude
    mag = neg ? (~value + 32'd1) : value;
    nd  = 0;
    do begin
      digs[nd] = 4'(mag % 32'd10);
      nd++;
      mag = mag / 32'd10;
    end while (mag != 0 && nd < NUM_DIGITS);
    if (neg) begin
      text_q.push_back('{code: CHAR_MINUS, is_last: 1'b0});
    end
    for (int k = nd; k > 0; k--) begin
      text_q.push_back('{code: CHAR_ZERO + CHAR_W'(digs[k-1]), is_last: (k == 1)});
    end
  endtask

  task automatic flag_mismatch(input text_char_t want, input logic [7:0] got_data,
                               input logic got_last, input logic had_want);
    if (errors < 10) begin
      if (had_want) begin
        $display("%0t: char mismatch: got data 0x%02h last %0b, wanted data 0x%02h last %0b",
                 $realtime, got_data, got_last, {2'b00, want.code}, want.is_last);
      end else begin
        $display("%0t: unexpected char: data 0x%02h last %0b", $realtime, got_data, got_last);
      end
    end
    errors++;
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        format_decimal(s_axis_tdata);
        n_values++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_chars++;
        if (text_q.size() == 0) begin
          flag_mismatch('0, m_axis_tdata, m_axis_tlast, 1'b0);
        end else begin
          want = text_q.pop_front();
          if (m_axis_tdata != {2'b00, want.code} || m_axis_tlast != want.is_last) begin
            flag_mismatch(want, m_axis_tdata, m_axis_tlast, 1'b1);
          end
        end
      end
      pending = text_q.size();
    end
  end

endmodule

// ===== test/signed_int_to_decimal_ascii_test.sv =====
// Top of the signed_int_to_decimal_ascii testbench: clock, reset, value stimulus and
// output ready pattern, including a long output stall. Checking lives in
// signed_int_to_decimal_ascii_checker; depends on that module and the RTL.
module signed_int_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] value (signed)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [5:0] text_char, [7:6] zero
  logic        m_axis_tlast;         // last_char

  int errors, pending, n_values, n_chars;
  int sent = 0;
  bit idle_on = 1'b1;
  bit stall_done = 1'b0;

  localparam int HOLD_CYCLES = 400;
  localparam int NUM_RANDOM  = 310;

  signed_int_to_decimal_ascii u_top (.*);

  signed_int_to_decimal_ascii_checker u_checker (.*);

  initial begin
    forever #2ns clk = ~clk;
  end

  initial begin
    #1ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Magnitude of a random digit count, random sign.
  function automatic logic [31:0] shaped_value();
    int unsigned d, lo, hi, mag;
    longint      p;
    logic        neg;
    d   = $urandom_range(10, 1);
    neg = 1'($urandom_range(1, 0));
    p   = 1;
    for (int i = 1; i < d; i++) p = p * 10;
    lo = (d == 1) ? 0 : 32'(p);
    p  = p * 10 - 1;
    if (neg && p > 64'd2147483648) p = 64'd2147483648;
    if (!neg && p > 64'd2147483647) p = 64'd2147483647;
    hi  = 32'(p);
    mag = $urandom_range(hi, lo);
    return neg ? (~mag + 32'd1) : mag;
  endfunction

  task automatic send_value(input logic [31:0] value);
    // idle per cycle: each further idle cycle follows with the same odds
    if (idle_on && $urandom_range(99, 0) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while (idle_on && $urandom_range(99, 0) < 14) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Output ready: random idling, plus one long hold once the pipe has traffic.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!stall_done && sent >= 60) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99, 0) < 14);
      end
    end
  end

  initial begin
    logic [31:0] directed[] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      -32'sd100, 32'd2147483647, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
      32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd1234567890,
      -32'sd1234567890, 32'd4294, 32'h5555_5555, 32'hAAAA_AAAA
    };
    int kind;
    logic [31:0] v;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // a stretch with back-to-back traffic on both sides
      idle_on = !(n >= 120 && n < 200);
      kind = $urandom_range(9, 0);
      if (kind < 3) begin
        v = $urandom();
      end else if (kind == 3) begin
        // powers of ten and neighbors
        v = 32'd1;
        repeat ($urandom_range(9, 0)) v = v * 32'd10;
        v = v + 32'($urandom_range(2, 0)) - 32'd1;
        if ($urandom_range(1, 0)) v = ~v + 32'd1;
      end else begin
        v = shaped_value();
      end
      send_value(v);
    end
    idle_on = 1'b1;
    s_axis_tvalid <= 1'b0;

    // let the checker book the last request before watching the backlog
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Converted %0d values into %0d characters: both 32-bit extremes, zero,",
             n_values, n_chars);
    $display("every digit count and sign, random idling and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
